// ===== design/ibus_pkg.sv =====
// Shared types and constants for the serial frame receiver.
// No dependencies; ibus_dp, ibus_ctrl and the top level import this package.
package ibus_pkg;

    localparam int FRAME_BYTES  = 32;
    localparam int SUMMED_BYTES = 30;
    localparam int POS_W        = 5;
    localparam int WORD_AW      = 4;
    localparam int WORD_DEPTH   = FRAME_BYTES / 2;
    localparam int CH_W         = 4;
    localparam int CFG_INDEX_W  = 4;

    localparam logic [15:0] SUM_START   = 16'hFFFF;
    localparam logic [7:0]  HDR_LEN_RST = 8'h20;
    localparam logic [7:0]  HDR_CMD_RST = 8'h40;

    localparam logic [CFG_INDEX_W-1:0] CFG_HDR_LEN = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_HDR_CMD = CFG_INDEX_W'(1);

    localparam logic FRAME_GOOD = 1'b0;
    localparam logic FRAME_BAD  = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_idle;
    } in_word_t;

    typedef struct packed {
        logic [CH_W-1:0] channel_index;
        logic [15:0]     channel_value;
        logic            frame_status;
        logic            last_of_frame;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_FETCH,
        ST_EMIT,
        ST_ERR
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;        // input word accepted this cycle
        logic ch_clear;
        logic ch_next;
        logic load_chan;
        logic load_err;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic frame_end;   // current input is the final frame byte
        logic sum_ok;      // checksum matches for the current input
        logic ch_last;
        logic slot_free;   // output register can take a word
    } stat_t;

endpackage

// ===== design/ibus_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ibus_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ibus_dp.sv =====
// Datapath: header registers, byte position, checksum, frame store, output register.
// Depends on ibus_pkg and ibus_ram.
module ibus_dp
    import ibus_pkg::*;
#(
    parameter int CHANNEL_COUNT = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  in_word_t               in_word,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    output out_word_t              out_word,
    output logic                   out_valid,
    input  logic                   out_stall
);

    logic [7:0]       hdr_len_reg;
    logic [7:0]       hdr_cmd_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       lo_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;

    logic             byte_in;
    logic             hdr_bad;
    logic             ram_we;
    logic [15:0]      ram_rdata;
    logic [WORD_AW-1:0] rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_len_reg <= HDR_LEN_RST;
            hdr_cmd_reg <= HDR_CMD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HDR_LEN: hdr_len_reg <= cfg_data;
                CFG_HDR_CMD: hdr_cmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign byte_in = cmd.take && !in_word.line_idle;
    assign hdr_bad = ((pos_reg == POS_W'(0)) && (in_word.rx_byte != hdr_len_reg))
                  || ((pos_reg == POS_W'(1)) && (in_word.rx_byte != hdr_cmd_reg));

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (cmd.take)
        begin
            if (in_word.line_idle || hdr_bad || (pos_reg == POS_W'(FRAME_BYTES - 1)))
            begin
                pos_next = '0;
                sum_next = SUM_START;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < POS_W'(SUMMED_BYTES))
                begin
                    sum_next = sum_reg - {8'h00, in_word.rx_byte};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= SUM_START;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Hold the even byte; odd bytes complete a little-endian word.
    always_ff @(posedge clk)
    begin
        if (byte_in && !pos_reg[0])
        begin
            lo_reg <= in_word.rx_byte;
        end
    end

    assign ram_we  = byte_in && pos_reg[0];
    assign rd_addr = ch_reg + WORD_AW'(1);

    ibus_ram #(
        .WIDTH (16),
        .DEPTH (WORD_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (pos_reg[POS_W-1:1]),
        .wr_data ({in_word.rx_byte, lo_reg}),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
        end
        else if (cmd.ch_clear)
        begin
            ch_reg <= '0;
        end
        else if (cmd.ch_next)
        begin
            ch_reg <= ch_reg + CH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_chan || cmd.load_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_chan)
        begin
            out_word_reg.channel_index <= ch_reg;
            out_word_reg.channel_value <= ram_rdata;
            out_word_reg.frame_status  <= FRAME_GOOD;
            out_word_reg.last_of_frame <= stat.ch_last;
        end
        else if (cmd.load_err)
        begin
            out_word_reg.channel_index <= '0;
            out_word_reg.channel_value <= '0;
            out_word_reg.frame_status  <= FRAME_BAD;
            out_word_reg.last_of_frame <= 1'b1;
        end
    end

    assign stat.frame_end = !in_word.line_idle && (pos_reg == POS_W'(FRAME_BYTES - 1));
    assign stat.sum_ok    = ({in_word.rx_byte, lo_reg} == sum_reg);
    assign stat.ch_last   = (ch_reg == CH_W'(CHANNEL_COUNT - 1));
    assign stat.slot_free = !out_valid_reg || !out_stall;

    assign out_word  = out_word_reg;
    assign out_valid = out_valid_reg;

    a_load_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_chan && cmd.load_err))
        else $error("channel and error loads together");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_chan || cmd.load_err) |-> stat.slot_free)
        else $error("output word overwritten before taken");

    a_no_take_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_chan || cmd.ch_next) |-> !cmd.take)
        else $error("input taken during channel emission");

endmodule

// ===== design/ibus_ctrl.sv =====
// Controller: hunts bytes, then sequences channel or error results.
// Depends on ibus_pkg.
module ibus_ctrl
    import ibus_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_HUNT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.frame_end)
                    begin
                        cmd.ch_clear = 1'b1;
                        state_next   = stat.sum_ok ? ST_FETCH : ST_ERR;
                    end
                end
            end
            ST_FETCH:
            begin
                // wait out the store read latency
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_chan = 1'b1;
                    if (stat.ch_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.ch_next = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_ERR:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_err = 1'b1;
                    state_next   = ST_HUNT;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    a_frame_end_leaves_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && stat.frame_end) |=> (state_reg != ST_HUNT))
        else $error("frame end did not start result sequence");

endmodule

// ===== design/ibus_frame_receiver.sv =====
// Top level of the serial frame receiver: controller plus datapath.
// Depends on ibus_pkg, ibus_ctrl, ibus_dp (and ibus_ram through ibus_dp).
//
//  Channel | Handshake            | Payload                 | Word
//  --------+----------------------+-------------------------+------------------------------
//  in      | in_valid / in_stall  | in_word  (in_word_t)    | one rx byte or idle event
//  out     | out_valid / out_stall| out_word (out_word_t)   | one channel or error result
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data     | one header register write
//
// Each received byte or idle event is taken in the same cycle it is offered while hunting.
// After the final frame byte the input stalls while results go out: each channel
// passes through a store read state (ST_FETCH) and an output load state (ST_EMIT),
// and a checksum error loads one error word from ST_ERR; any output stall adds to this.
// The frame store is a 16 x 16 RAM of little-endian words; its registered read
// port is why each channel needs the ST_FETCH state before it is loaded.
// Reset sets position, checksum, state and header registers to their start values; the store needs
// no clearing since every word is written before it is read within a frame.
// A stalled output word holds; the next input is accepted while it waits.
module ibus_frame_receiver
    import ibus_pkg::*;
#(
    parameter int CHANNEL_COUNT = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Header writes must arrive only while idle; the block does not enforce this and always takes them.
    assign cfg_ready = 1'b1;

    ibus_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ibus_dp #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

// ===== sim/ibus_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ibus_frame_receiver: header and checksum handling, channel decode.
// Depends on ibus_pkg and the design sources; stands alone otherwise.
module ibus_frame_receiver_tb
    import ibus_pkg::*;
();

    localparam int CHANNELS     = 14;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, long enough to back up a frame
    localparam int DRAIN_CYCLES = 64;    // settling margin for the output pipe after the last owed word is out
    localparam int STUCK_LIMIT  = 5000;  // cycles with no handshake at all before giving up
    localparam int SHOWN_ERRORS = 10;

    // Predictor of the frame decoder plus the queue of channel words it still owes.
    class ibus_channel_board;
        logic [7:0]  hdr_len;
        logic [7:0]  hdr_cmd;
        logic [7:0]  frame_mem [FRAME_BYTES];
        logic [4:0]  pos;
        logic [15:0] csum;
        out_word_t   channels_due [$];
        int          mismatches;

        function new();
            hdr_len    = HDR_LEN_RST;
            hdr_cmd    = HDR_CMD_RST;
            pos        = '0;
            csum       = SUM_START;
            mismatches = 0;
            foreach (frame_mem[i])
                frame_mem[i] = '0;
        endfunction

        function void set_header(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_HDR_LEN)
                hdr_len = data;
            else if (idx == CFG_HDR_CMD)
                hdr_cmd = data;
        endfunction

        function int pending();
            return channels_due.size();
        endfunction

        function void restart_hunt();
            pos  = '0;
            csum = SUM_START;
        endfunction

        // Advance the frame state by one accepted input word.
        function void absorb_rx_word(in_word_t w);
            logic [15:0] frame_sum;
            out_word_t   r;
            if (w.line_idle)
            begin
                restart_hunt();
                return;
            end
            if ((pos == 0 && w.rx_byte != hdr_len) || (pos == 1 && w.rx_byte != hdr_cmd))
            begin
                restart_hunt();
                return;
            end
            frame_mem[pos] = w.rx_byte;
            if (pos < SUMMED_BYTES)
                csum = csum - 16'(w.rx_byte);
            if (pos != 5'(FRAME_BYTES - 1))
            begin
                pos = pos + 5'd1;
                return;
            end
            frame_sum = {frame_mem[31], frame_mem[30]};
            if (frame_sum == csum)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    r.channel_index = CH_W'(i);
                    r.channel_value = {frame_mem[2*i+3], frame_mem[2*i+2]};
                    r.frame_status  = FRAME_GOOD;
                    r.last_of_frame = (i == CHANNELS - 1);
                    channels_due.push_back(r);
                end
            end
            else
            begin
                r.channel_index = '0;
                r.channel_value = '0;
                r.frame_status  = FRAME_BAD;
                r.last_of_frame = 1'b1;
                channels_due.push_back(r);
            end
            restart_hunt();
        endfunction

        function void report(string what, out_word_t exp_w, out_word_t got);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("%0t %s: exp idx/val/st/last %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                         $realtime, what, exp_w.channel_index, exp_w.channel_value,
                         exp_w.frame_status, exp_w.last_of_frame, got.channel_index,
                         got.channel_value, got.frame_status, got.last_of_frame);
        endfunction

        // Compare one accepted output word against the oldest owed word.
        function void check_channel_word(out_word_t got);
            out_word_t exp_w;
            if (channels_due.size() == 0)
            begin
                report("unexpected output word", '0, got);
                return;
            end
            exp_w = channels_due.pop_front();
            if (got.channel_index !== exp_w.channel_index ||
                got.channel_value !== exp_w.channel_value ||
                got.frame_status  !== exp_w.frame_status  ||
                got.last_of_frame !== exp_w.last_of_frame)
                report("output word mismatch", exp_w, got);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_word_t               in_word   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_word_t              out_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    ibus_channel_board sb;
    logic [7:0] frame_buf [FRAME_BYTES];
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  items_sent    = 0;
    int  stuck_cycles  = 0;
    int  hold_left     = 0;
    bit  long_hold_req = 1'b0;

    ibus_frame_receiver #(
        .CHANNEL_COUNT(CHANNELS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: sample both handshakes on the pre-edge values, feed the predictor and checker,
    // and count cycles in which nothing moves for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.absorb_rx_word(in_word);
            if (out_valid && !out_stall)
                sb.check_channel_word(out_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Watchdog: drop the run if no word moves for too long.
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stall at the current idle rate, or a long hold-off when asked for one.
    // The hold-off is counted here so the sender keeps offering words meanwhile.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offer one input word, with random idle cycles in front, and hold it until accepted.
    // Returns at the edge that took it, with no assignment made yet in that step.
    task automatic send_word(in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        in_word_t w;
        w.rx_byte   = b;
        w.line_idle = 1'b0;
        send_word(w);
    endtask

    // Idle-line event; the byte lane carries junk that must be ignored.
    task automatic send_idle(logic [7:0] junk);
        in_word_t w;
        w.rx_byte   = junk;
        w.line_idle = 1'b1;
        send_word(w);
    endtask

    // Header from the current registers, random channel payload.
    function automatic void fill_frame();
        frame_buf[0] = sb.hdr_len;
        frame_buf[1] = sb.hdr_cmd;
        for (int i = 2; i < SUMMED_BYTES; i++)
            frame_buf[i] = 8'($urandom);
    endfunction

    // Append the checksum word; corrupt flips some bits of it so the frame must be rejected.
    function automatic void seal_frame(bit corrupt);
        logic [15:0] s;
        s = SUM_START;
        for (int i = 0; i < SUMMED_BYTES; i++)
            s = s - 16'(frame_buf[i]);
        frame_buf[30] = s[7:0];
        frame_buf[31] = s[15:8];
        if (corrupt)
            frame_buf[30 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    endfunction

    task automatic send_frame_bytes(int n);
        for (int i = 0; i < n; i++)
            send_byte(frame_buf[i]);
    endtask

    // Lower valid and wait until every owed word has come out, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both header registers back to back; only called while the block is idle.
    task automatic write_headers(logic [7:0] len_byte, logic [7:0] cmd_byte);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HDR_LEN;
        cfg_data  <= len_byte;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_header(CFG_HDR_LEN, len_byte);
        cfg_index <= CFG_HDR_CMD;
        cfg_data  <= cmd_byte;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_header(CFG_HDR_CMD, cmd_byte);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly whole frames with random payload, plus broken ones and noise.
    // Every sequence leaves the hunt back at the frame start.
    task automatic run_traffic(int n_items);
        int target;
        int kind;
        int noise_len;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 9);
            fill_frame();
            if (kind <= 5)
            begin
                seal_frame(1'b0);
                send_frame_bytes(FRAME_BYTES);
            end
            else if (kind == 6)
            begin
                seal_frame(1'b1);
                send_frame_bytes(FRAME_BYTES);
            end
            else if (kind == 7)
            begin
                // abort a partial frame with an idle event
                seal_frame(1'b0);
                send_frame_bytes($urandom_range(1, FRAME_BYTES - 1));
                send_idle(8'($urandom));
            end
            else if (kind == 8)
            begin
                send_byte(sb.hdr_len);
                send_byte(sb.hdr_cmd ^ 8'($urandom_range(1, 255)));
            end
            else
            begin
                noise_len = $urandom_range(1, 4);
                for (int i = 0; i < noise_len; i++)
                begin
                    if ($urandom_range(0, 1))
                        send_idle(8'($urandom));
                    else
                        send_byte(8'($urandom));
                end
                send_idle(8'($urandom));
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 83;

        // Directed part at the reset header values.
        send_idle(8'hFF);                  // idle event, byte lane ignored
        send_idle(HDR_LEN_RST);            // idle carrying the header byte must not start a frame
        send_byte(8'h00);                  // wrong first byte, both extremes
        send_byte(8'hFF);
        send_byte(HDR_LEN_RST);            // wrong second byte equal to the length byte:
        send_byte(HDR_LEN_RST);            // it is dropped, not taken as a new frame start
        send_byte(HDR_LEN_RST);            // header, then an idle abort
        send_byte(HDR_CMD_RST);
        send_idle(8'h00);
        fill_frame();                      // good frame with extreme channel values
        frame_buf[2]  = 8'h00;
        frame_buf[3]  = 8'h00;
        frame_buf[28] = 8'hFF;
        frame_buf[29] = 8'hFF;
        seal_frame(1'b0);
        send_frame_bytes(FRAME_BYTES);
        fill_frame();                      // checksum mismatch
        seal_frame(1'b1);
        send_frame_bytes(FRAME_BYTES);

        // Sender idles lightly, receiver heavily.
        drain();
        write_headers(8'h00, 8'hFF);
        run_traffic(15);

        // The other way round.
        drain();
        write_headers(8'hFF, 8'h00);
        send_idle_pct = 83;
        recv_idle_pct = 24;
        run_traffic(15);

        // No idling; first back the block up behind a long receiver hold-off.
        drain();
        write_headers(HDR_LEN_RST, HDR_CMD_RST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
        for (int f = 0; f < 2; f++)
        begin
            fill_frame();
            seal_frame(1'b0);
            send_frame_bytes(FRAME_BYTES);
        end
        drain();                           // pause the sender until all words are out
        run_traffic(5);

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/ibus_pkg.sv
design/ibus_ram.sv
design/ibus_dp.sv
design/ibus_ctrl.sv
design/ibus_frame_receiver.sv
sim/ibus_frame_receiver_tb.sv
